// ===== hw/rtl/pmie_pkg.sv =====
// Package for the protected-mode interrupt entry block.
// Holds the beat structs, field codes and read phase codes.
// No dependencies.
package pmie_pkg;

    localparam int unsigned ADDR_W   = 32;
    localparam int unsigned SEL_W    = 16;
    localparam int unsigned LIMIT_W  = 20;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic        ACTION_RAISE = 1'b0;
    localparam logic        ACTION_RESP  = 1'b1;

    localparam logic [1:0]  KIND_WRITE = 2'd0;
    localparam logic [1:0]  KIND_READ  = 2'd1;
    localparam logic [1:0]  KIND_DONE  = 2'd2;

    localparam logic        SPACE_STACK  = 1'b0;
    localparam logic        SPACE_LINEAR = 1'b1;

    localparam logic [2:0]  BYTES_NONE = 3'd0;
    localparam logic [2:0]  BYTES_1    = 3'd1;
    localparam logic [2:0]  BYTES_2    = 3'd2;
    localparam logic [2:0]  BYTES_4    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_IDT_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GDT_BASE = 1'd1;

    typedef enum logic [3:0] {
        PH_GATE_SEL  = 4'd0,
        PH_BASE_LO   = 4'd1,
        PH_BASE_MID  = 4'd2,
        PH_BASE_HI   = 4'd3,
        PH_LIMIT_LO  = 4'd4,
        PH_LIMIT_HI  = 4'd5,
        PH_OFF_LO    = 4'd6,
        PH_OFF_HI    = 4'd7
    } t_phase;

    typedef struct packed {
        logic        action;
        logic [7:0]  vector;
        logic [31:0] stack_pointer;
        logic [31:0] flags_word;
        logic [15:0] code_selector;
        logic [31:0] instr_pointer;
        logic [15:0] read_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] address;
        logic        addr_space;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
        logic [31:0] new_pointer;
        logic [15:0] new_selector;
        logic [31:0] new_stack_pointer;
        logic [31:0] code_base;
        logic [19:0] code_limit;
        logic        last;
    } t_out_item;

endpackage

// ===== hw/rtl/protected_mode_interrupt_entry_top.sv =====
// Top level of the protected-mode interrupt entry sequencer.
// Depends on pmie_pkg for beat structs and codes.
//
// Usage:
//   Input channel i_in_valid / i_in_item / o_in_stall carries raise beats
//   and read-response beats. Output channel o_out_valid / o_out_item /
//   i_out_stall carries write, read-request and done beats.
//   A raise emits four beats: three stack pushes and the gate selector
//   read; once it is accepted, the input stays stalled while the remaining
//   push beats and the gate selector read leave the output register.
//   Each read response gives one beat in the cycle after acceptance, and a
//   new response may be accepted every cycle unless the output stalls.
//   A raise while busy and a response while idle are accepted and give no beat.
//   The eighth response gives the done beat with the handler pointer,
//   gate selector, stack pointer and cached code base and limit.
//   When the receiver stalls, the output register holds its beat and the
//   input is stalled until the beat leaves. Reset clears both table bases
//   and returns the block to idle with no beat pending. The user must write
//   table bases through i_cfg_we only while idle; the block does not enforce it.
module protected_mode_interrupt_entry_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pmie_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    input  logic                                i_in_valid,
    input  pmie_pkg::t_in_item                  i_in_item,
    output logic                                o_in_stall,
    output logic                                o_out_valid,
    output pmie_pkg::t_out_item                 o_out_item,
    input  logic                                i_out_stall
);

    logic [31:0]               r_idt_base;
    logic [31:0]               r_gdt_base;
    logic                      r_busy,  n_busy;
    pmie_pkg::t_phase          r_phase, n_phase;
    logic [7:0]                r_saved_vector, n_saved_vector;
    logic [31:0]               r_saved_stack,  n_saved_stack;
    logic [15:0]               r_gate_selector, n_gate_selector;
    logic [31:0]               r_seg_base,  n_seg_base;
    logic [19:0]               r_seg_limit, n_seg_limit;
    logic [15:0]               r_offset_low, n_offset_low;
    logic [15:0]               r_push_cs,   n_push_cs;
    logic [31:0]               r_push_ip,   n_push_ip;
    logic [1:0]                r_push_left, n_push_left;
    logic                      r_out_valid, n_out_valid;
    pmie_pkg::t_out_item       r_out, n_out;

    logic                      can_load;
    logic                      in_accept;
    logic [31:0]               gate_addr;
    logic [31:0]               desc_addr;
    logic [31:0]               desc_addr_new;

    assign can_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_push_left != 2'd0) || !can_load;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign gate_addr     = r_idt_base + {21'd0, r_saved_vector, 3'd0};
    assign desc_addr     = r_gdt_base + {16'd0, r_gate_selector[15:3], 3'd0};
    assign desc_addr_new = r_gdt_base + {16'd0, i_in_item.read_data[15:3], 3'd0};

    always_comb begin
        n_busy          = r_busy;
        n_phase         = r_phase;
        n_saved_vector  = r_saved_vector;
        n_saved_stack   = r_saved_stack;
        n_gate_selector = r_gate_selector;
        n_seg_base      = r_seg_base;
        n_seg_limit     = r_seg_limit;
        n_offset_low    = r_offset_low;
        n_push_cs       = r_push_cs;
        n_push_ip       = r_push_ip;
        n_push_left     = r_push_left;
        n_out_valid     = r_out_valid;
        n_out           = r_out;

        if (can_load) begin
            n_out_valid = 1'b0;
            n_out       = '0;
        end

        if (can_load && r_push_left != 2'd0) begin
            n_out_valid = 1'b1;
            n_push_left = r_push_left - 2'd1;
            case (r_push_left)
                2'd3: begin
                    n_out.kind         = pmie_pkg::KIND_WRITE;
                    n_out.address      = r_saved_stack + 32'd4;
                    n_out.addr_space   = pmie_pkg::SPACE_STACK;
                    n_out.access_bytes = pmie_pkg::BYTES_4;
                    n_out.write_data   = {16'd0, r_push_cs};
                end
                2'd2: begin
                    n_out.kind         = pmie_pkg::KIND_WRITE;
                    n_out.address      = r_saved_stack;
                    n_out.addr_space   = pmie_pkg::SPACE_STACK;
                    n_out.access_bytes = pmie_pkg::BYTES_4;
                    n_out.write_data   = r_push_ip;
                end
                default: begin
                    n_out.kind         = pmie_pkg::KIND_READ;
                    n_out.address      = gate_addr + 32'd2;
                    n_out.addr_space   = pmie_pkg::SPACE_LINEAR;
                    n_out.access_bytes = pmie_pkg::BYTES_2;
                    n_out.last         = 1'b1;
                end
            endcase
        end else if (in_accept) begin
            if (i_in_item.action == pmie_pkg::ACTION_RAISE) begin
                if (!r_busy) begin
                    n_saved_vector     = i_in_item.vector;
                    n_saved_stack      = i_in_item.stack_pointer - 32'd12;
                    n_push_cs          = i_in_item.code_selector;
                    n_push_ip          = i_in_item.instr_pointer;
                    n_push_left        = 2'd3;
                    n_busy             = 1'b1;
                    n_phase            = pmie_pkg::PH_GATE_SEL;
                    n_out_valid        = 1'b1;
                    n_out.kind         = pmie_pkg::KIND_WRITE;
                    n_out.address      = i_in_item.stack_pointer - 32'd4;
                    n_out.addr_space   = pmie_pkg::SPACE_STACK;
                    n_out.access_bytes = pmie_pkg::BYTES_4;
                    n_out.write_data   = i_in_item.flags_word;
                end
            end else if (r_busy) begin
                n_out_valid      = 1'b1;
                n_out.kind       = pmie_pkg::KIND_READ;
                n_out.addr_space = pmie_pkg::SPACE_LINEAR;
                n_out.last       = 1'b1;
                n_phase          = pmie_pkg::t_phase'(r_phase + 4'd1);
                case (r_phase)
                    pmie_pkg::PH_GATE_SEL: begin
                        n_gate_selector    = i_in_item.read_data;
                        n_out.address      = desc_addr_new + 32'd2;
                        n_out.access_bytes = pmie_pkg::BYTES_2;
                    end
                    pmie_pkg::PH_BASE_LO: begin
                        n_seg_base         = {16'd0, i_in_item.read_data};
                        n_out.address      = desc_addr + 32'd4;
                        n_out.access_bytes = pmie_pkg::BYTES_1;
                    end
                    pmie_pkg::PH_BASE_MID: begin
                        n_seg_base         = {8'd0, i_in_item.read_data[7:0],
                                              r_seg_base[15:0]};
                        n_out.address      = desc_addr + 32'd7;
                        n_out.access_bytes = pmie_pkg::BYTES_1;
                    end
                    pmie_pkg::PH_BASE_HI: begin
                        n_seg_base         = {i_in_item.read_data[7:0], r_seg_base[23:0]};
                        n_out.address      = desc_addr;
                        n_out.access_bytes = pmie_pkg::BYTES_2;
                    end
                    pmie_pkg::PH_LIMIT_LO: begin
                        n_seg_limit        = {4'd0, i_in_item.read_data};
                        n_out.address      = desc_addr + 32'd6;
                        n_out.access_bytes = pmie_pkg::BYTES_1;
                    end
                    pmie_pkg::PH_LIMIT_HI: begin
                        n_seg_limit        = {i_in_item.read_data[3:0], r_seg_limit[15:0]};
                        n_out.address      = gate_addr;
                        n_out.access_bytes = pmie_pkg::BYTES_2;
                    end
                    pmie_pkg::PH_OFF_LO: begin
                        n_offset_low       = i_in_item.read_data;
                        n_out.address      = gate_addr + 32'd6;
                        n_out.access_bytes = pmie_pkg::BYTES_2;
                    end
                    pmie_pkg::PH_OFF_HI: begin
                        n_out                   = '0;
                        n_out.kind              = pmie_pkg::KIND_DONE;
                        n_out.new_pointer       = r_seg_base
                                                + {i_in_item.read_data, r_offset_low};
                        n_out.new_selector      = r_gate_selector;
                        n_out.new_stack_pointer = r_saved_stack;
                        n_out.code_base         = r_seg_base;
                        n_out.code_limit        = r_seg_limit;
                        n_out.last              = 1'b1;
                        n_busy                  = 1'b0;
                        n_phase                 = pmie_pkg::PH_GATE_SEL;
                    end
                    default: begin
                        n_out_valid = 1'b0;
                        n_out       = '0;
                        n_busy      = 1'b0;
                        n_phase     = pmie_pkg::PH_GATE_SEL;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idt_base  <= '0;
            r_gdt_base  <= '0;
            r_busy      <= 1'b0;
            r_phase     <= pmie_pkg::PH_GATE_SEL;
            r_push_left <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pmie_pkg::REG_IDT_BASE: r_idt_base <= i_cfg_data;
                    pmie_pkg::REG_GDT_BASE: r_gdt_base <= i_cfg_data;
                    default: ;
                endcase
            end
            r_busy      <= n_busy;
            r_phase     <= n_phase;
            r_push_left <= n_push_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_saved_vector  <= n_saved_vector;
        r_saved_stack   <= n_saved_stack;
        r_gate_selector <= n_gate_selector;
        r_seg_base      <= n_seg_base;
        r_seg_limit     <= n_seg_limit;
        r_offset_low    <= n_offset_low;
        r_push_cs       <= n_push_cs;
        r_push_ip       <= n_push_ip;
        r_out           <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
